FILE: hw/rtl/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Shared constants, soft-clip tables and interface types of the frame-based
// gain control block with soft limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package agc_pkg;

   // frame geometry
   localparam int MAX_FRAME_ORDER = 5;
   localparam int MIN_FRAME_ORDER = 3;
   // frame length count, wide enough for the largest supported frame order (5)
   localparam int FILL_W          = 7;

   // sample and gain formats
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 27;
   localparam int GAIN_INT_W = 11;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 3;

   localparam logic [GAIN_W-1:0] GAIN_HI = 27'd67108864;   // 1024.0 in Q11.16, a gain of 4.0 (numerator over 256)
   localparam logic [GAIN_W-1:0] GAIN_LO = 27'd16777216;   // 256.0 in Q11.16, a gain of 1.0 (numerator over 256)

   localparam logic [14:0] LIMIT_ONSET = 15'd31744;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ORDER     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INCREMENT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DECREMENT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_FRAMES     = 3'd4;

   // soft-clip slope and knee, picked by bits 9..6 of the excess
   localparam logic [7:0] SLOPE_TAB [16] = '{
      8'd244, 8'd232, 8'd220, 8'd208, 8'd196, 8'd184, 8'd172, 8'd160,
      8'd148, 8'd136, 8'd124, 8'd112, 8'd100, 8'd88,  8'd76,  8'd64
   };
   localparam logic [14:0] KNEE_TAB [16] = '{
      15'd31744, 15'd31747, 15'd31753, 15'd31762,
      15'd31774, 15'd31789, 15'd31807, 15'd31828,
      15'd31852, 15'd31879, 15'd31909, 15'd31942,
      15'd31978, 15'd32017, 15'd32059, 15'd32104
   };

   typedef struct packed {
      logic [2:0]  frame_order;
      logic [30:0] power_threshold;
      logic [25:0] gain_increment;
      logic [25:0] gain_decrement;
      logic [15:0] hold_frames;
   } cfg_type;

   // one finished frame handed from the front to the back
   typedef struct packed {
      logic                  bank;
      logic [FILL_W-1:0]     count;
      logic [GAIN_INT_W-1:0] gain;
   } desc_type;

   // back tells the front that a buffer bank has been fully read
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

`default_nettype wire

FILE: hw/rtl/agc_front.sv
// ----------------------------------------------------------------------------
// agc_front
// Accepts samples, writes them into the free buffer bank, sums their squares
// and, at the end of a frame, updates gain and hold and queues the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module agc_front #(
   parameter int MAX_FRAME_ORDER = agc_pkg::MAX_FRAME_ORDER
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire agc_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [agc_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                               wr_en,
   output logic [MAX_FRAME_ORDER:0]           wr_addr,
   output logic [agc_pkg::SAMPLE_W-1:0]       wr_data,
   output logic                               push,
   output agc_pkg::desc_type                  push_desc,
   input  wire logic                          queue_full,
   input  wire agc_pkg::release_type          release_info
);

   localparam int FW = MAX_FRAME_ORDER + 1;
   localparam int EW = 31 + MAX_FRAME_ORDER;
   localparam int CW = agc_pkg::FILL_W;
   localparam int GW = agc_pkg::GAIN_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ACC    = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [EW-1:0] energy_ff, energy_in;
   logic [30:0]   sq_ff, sq_in;
   logic          loud_ff, loud_in;
   logic [GW-1:0] gain_ff, gain_in;
   logic [15:0]   hold_ff, hold_in;
   logic          wbank_ff, wbank_in;
   logic [1:0]    busy_ff, busy_in;

   logic                 accept;
   logic [2:0]           order_eff;
   logic [FW-1:0]        frame_len;
   logic [FW-1:0]        fill_next;
   logic signed [31:0]   square;
   logic signed [GW:0]   gain_sum;
   logic [GW-1:0]        gain_clamped;

   // effective frame order, clamped to the supported range
   always_comb begin
      if (cfg.frame_order > 3'(MAX_FRAME_ORDER)) begin
         order_eff = 3'(MAX_FRAME_ORDER);
      end else if (cfg.frame_order < 3'(agc_pkg::MIN_FRAME_ORDER)) begin
         order_eff = 3'(agc_pkg::MIN_FRAME_ORDER);
      end else begin
         order_eff = cfg.frame_order;
      end
   end

   assign frame_len = FW'(1) << order_eff;
   assign fill_next = fill_ff + FW'(1);

   // request handshake and buffer write
   assign req_stall = (state_ff != ST_IDLE) || busy_ff[wbank_ff];
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept;
   assign wr_addr   = {wbank_ff, fill_ff[MAX_FRAME_ORDER-1:0]};
   assign wr_data   = req_sample_in;
   assign square    = $signed(req_sample_in) * $signed(req_sample_in);

   // gain step and clamp
   always_comb begin
      if (loud_ff) begin
         gain_sum = $signed({1'b0, gain_ff}) - $signed({2'b0, cfg.gain_decrement});
      end else if (hold_ff != 16'd0) begin
         gain_sum = $signed({1'b0, gain_ff});
      end else begin
         gain_sum = $signed({1'b0, gain_ff}) + $signed({2'b0, cfg.gain_increment});
      end
      if (gain_sum > $signed({1'b0, agc_pkg::GAIN_HI})) begin
         gain_clamped = agc_pkg::GAIN_HI;
      end else if (gain_sum < $signed({1'b0, agc_pkg::GAIN_LO})) begin
         gain_clamped = agc_pkg::GAIN_LO;
      end else begin
         gain_clamped = gain_sum[GW-1:0];
      end
   end

   assign push = (state_ff == ST_UPDATE) && !queue_full;
   assign push_desc.bank  = wbank_ff;
   assign push_desc.count = CW'(fill_ff);
   assign push_desc.gain  = gain_clamped[GW-1:16];

   // front sequencer
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      energy_in = energy_ff;
      sq_in     = sq_ff;
      loud_in   = loud_ff;
      gain_in   = gain_ff;
      hold_in   = hold_ff;
      wbank_in  = wbank_ff;
      busy_in   = busy_ff;
      if (release_info.valid) begin
         busy_in[release_info.bank] = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sq_in    = square[30:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            energy_in = energy_ff + EW'(sq_ff);
            fill_in   = fill_next;
            state_in  = (fill_next >= frame_len) ? ST_DECIDE : ST_IDLE;
         end
         ST_DECIDE: begin
            loud_in  = (energy_ff >> order_eff) >= EW'(cfg.power_threshold);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (push) begin
               gain_in   = gain_clamped;
               if (loud_ff) begin
                  hold_in = cfg.hold_frames;
               end else if (hold_ff != 16'd0) begin
                  hold_in = hold_ff - 16'd1;
               end
               fill_in   = '0;
               energy_in = '0;
               busy_in[wbank_ff] = 1'b1;
               wbank_in  = !wbank_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         energy_ff <= '0;
         gain_ff   <= agc_pkg::GAIN_LO;
         hold_ff   <= '0;
         wbank_ff  <= 1'b0;
         busy_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         energy_ff <= energy_in;
         gain_ff   <= gain_in;
         hold_ff   <= hold_in;
         wbank_ff  <= wbank_in;
         busy_ff   <= busy_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      loud_ff <= loud_in;
   end

   // a bank is only handed back after it was queued
   a_release_busy : assert property (@(posedge clock) disable iff (reset)
      release_info.valid |-> busy_ff[release_info.bank])
      else $error("release of a bank that is not in use");

   // queuing a frame restarts the count and the energy sum
   a_push_clears : assert property (@(posedge clock) disable iff (reset)
      push |=> (fill_ff == '0) && (energy_ff == '0))
      else $error("frame state not cleared after queuing");

endmodule

`default_nettype wire

FILE: hw/rtl/agc_desc_fifo.sv
// ----------------------------------------------------------------------------
// agc_desc_fifo
// Two-entry queue of finished frames between the front and the back, so
// that sample intake and frame output stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module agc_desc_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire agc_pkg::desc_type push_desc,
   input  wire logic              pop,
   output agc_pkg::desc_type      pop_desc,
   output logic                   full,
   output logic                   empty
);

   localparam logic [1:0] DEPTH = 2'd2;

   agc_pkg::desc_type entry_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == DEPTH);
   assign empty    = (count_ff == 2'd0);
   assign pop_desc = entry_ff[rptr_ff];

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_desc;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("frame queue overflow");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("frame queue underflow");

endmodule

`default_nettype wire

FILE: hw/rtl/agc_back.sv
// ----------------------------------------------------------------------------
// agc_back
// Holds the two-bank frame buffer and plays queued frames out through the
// gain multiply, soft clip and saturation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module agc_back #(
   parameter int MAX_FRAME_ORDER = agc_pkg::MAX_FRAME_ORDER
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [MAX_FRAME_ORDER:0]        wr_addr,
   input  wire logic [agc_pkg::SAMPLE_W-1:0]    wr_data,
   input  wire logic                            queue_empty,
   input  wire agc_pkg::desc_type               queue_desc,
   output logic                                 pop,
   output agc_pkg::release_type                 release_info,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [agc_pkg::SAMPLE_W-1:0]         rsp_sample_out,
   output logic                                 rsp_frame_last,
   output logic [agc_pkg::GAIN_INT_W-1:0]       rsp_gain_applied
);

   localparam int DEPTH = 2 << MAX_FRAME_ORDER;
   localparam int CW    = agc_pkg::FILL_W;
   localparam int GI    = agc_pkg::GAIN_INT_W;
   localparam int SW    = agc_pkg::SAMPLE_W;

   // frame buffer, two banks
   logic [SW-1:0] mem [DEPTH];

   // playout control
   logic                       active_ff;
   logic                       bank_ff;
   logic [MAX_FRAME_ORDER-1:0] idx_ff;
   logic [CW-1:0]              cnt_ff;
   logic [GI-1:0]              gain_ff;

   // pipeline registers
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 last1_ff, last2_ff, last3_ff, last4_ff;
   logic [GI-1:0]        g1_ff, g2_ff, g3_ff, g4_ff;
   logic signed [SW-1:0] s1_ff;
   logic signed [18:0]   x2_ff, x3_ff, x4_ff;
   logic signed [18:0]   over3_ff;
   logic [3:0]           k3_ff, k4_ff;
   logic                 clip3_ff, clip4_ff, pos3_ff, pos4_ff;
   logic signed [27:0]   prod4_ff;
   logic                 rsp_valid_ff;
   logic [SW-1:0]        rsp_sample_ff;
   logic                 rsp_last_ff;
   logic [GI-1:0]        rsp_gain_ff;

   logic                 advance;
   logic                 issue;
   logic                 issue_last;
   logic signed [27:0]   mul2;
   logic [18:0]          xmag;
   logic signed [18:0]   over;
   logic [18:0]          omag;
   logic signed [27:0]   mul4;
   logic signed [18:0]   shifted;
   logic signed [19:0]   knee;
   logic signed [19:0]   y;
   logic [SW-1:0]        sat;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign issue      = active_ff && advance;
   assign issue_last = (CW'(idx_ff) + CW'(1)) == cnt_ff;
   assign pop        = !active_ff && !queue_empty;

   assign release_info.valid = issue && issue_last;
   assign release_info.bank  = bank_ff;

   // buffer write from the front
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // buffer read into the first stage
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff    <= mem[{bank_ff, idx_ff}];
         last1_ff <= issue_last;
         g1_ff    <= gain_ff;
      end
   end

   // frame playout sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (pop) begin
         active_ff <= 1'b1;
      end else if (issue && issue_last) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bank_ff <= queue_desc.bank;
         cnt_ff  <= queue_desc.count;
         gain_ff <= queue_desc.gain;
         idx_ff  <= '0;
      end else if (issue) begin
         idx_ff  <= idx_ff + MAX_FRAME_ORDER'(1);
      end
   end

   // gain multiply, floor of product over 256
   assign mul2 = s1_ff * $signed({1'b0, g1_ff});

   // excess over the limiter onset
   always_comb begin
      xmag = x2_ff[18] ? 19'(-x2_ff) : 19'(x2_ff);
      if (!x2_ff[18] && (x2_ff != '0)) begin
         over = x2_ff - $signed({4'b0, agc_pkg::LIMIT_ONSET});
      end else begin
         over = x2_ff + $signed({4'b0, agc_pkg::LIMIT_ONSET});
      end
      omag = over[18] ? 19'(-over) : 19'(over);
   end

   // slope multiply
   assign mul4 = over3_ff * $signed({1'b0, agc_pkg::SLOPE_TAB[k3_ff]});

   // knee add and saturation
   always_comb begin
      shifted = prod4_ff[26:8];
      knee    = $signed({5'b0, agc_pkg::KNEE_TAB[k4_ff]});
      if (!clip4_ff) begin
         y = 20'(x4_ff);
      end else if (pos4_ff) begin
         y = knee + 20'(shifted);
      end else begin
         y = 20'(shifted) - knee;
      end
      if (y > 20'sd32767) begin
         sat = 16'h7fff;
      end else if (y < -20'sd32768) begin
         sat = 16'h8000;
      end else begin
         sat = y[SW-1:0];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // pipeline data
   always_ff @(posedge clock) begin
      if (advance) begin
         x2_ff         <= mul2[26:8];
         last2_ff      <= last1_ff;
         g2_ff         <= g1_ff;
         x3_ff         <= x2_ff;
         over3_ff      <= over;
         k3_ff         <= omag[9:6];
         clip3_ff      <= xmag > 19'(agc_pkg::LIMIT_ONSET);
         pos3_ff       <= !x2_ff[18] && (x2_ff != '0);
         last3_ff      <= last2_ff;
         g3_ff         <= g2_ff;
         prod4_ff      <= mul4;
         x4_ff         <= x3_ff;
         k4_ff         <= k3_ff;
         clip4_ff      <= clip3_ff;
         pos4_ff       <= pos3_ff;
         last4_ff      <= last3_ff;
         g4_ff         <= g3_ff;
         rsp_sample_ff <= sat;
         rsp_last_ff   <= last4_ff;
         rsp_gain_ff   <= g4_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = rsp_sample_ff;
   assign rsp_frame_last   = rsp_last_ff;
   assign rsp_gain_applied = rsp_gain_ff;

   // the applied gain always lies within the clamp range
   a_gain_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gain_ff >= 11'd256) && (rsp_gain_ff <= 11'd1024))
      else $error("applied gain out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/audio_agc_soft_limiter_core.sv
// ----------------------------------------------------------------------------
// audio_agc_soft_limiter_core
// Frame-based automatic gain control with attack, hold and release, and a
// table-driven soft limiter on the output samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed 16-bit sample per request. Samples are buffered
//   into a frame of 2^frame_order samples; when the frame fills, its mean
//   energy updates the gain and hold, and the whole frame is sent on rsp_*,
//   one result per buffered sample, frame_last on the final one, together
//   with the gain numerator over 256 used for that frame.
//   Intake handles each sample as a buffer write and square, then an energy
//   accumulate; the sample that closes a frame goes on to the energy compare
//   and the gain update, which waits while the frame queue is full. Results
//   of a frame then follow one per cycle unless rsp_stall holds them, with
//   an idle slot between frames while the next one is popped from the queue.
//   Two buffer banks and a two-entry frame queue let a frame play out while
//   the next one fills; req_stall is high in the cycles after each accepted
//   sample and while the bank to be filled next is still queued or playing.
//   A stalled rsp_* holds its result and freezes the output pipeline only.
//   Reset (synchronous) restores the register defaults, gain 1.0, hold zero
//   and an empty frame; the buffer itself needs no clearing. csr_* writes a
//   register at any edge with csr_wr_en high; only the user keeps it to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_agc_soft_limiter_core #(
   parameter int MAX_FRAME_ORDER = agc_pkg::MAX_FRAME_ORDER
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [agc_pkg::SAMPLE_W-1:0]     req_sample_in,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [agc_pkg::SAMPLE_W-1:0]          rsp_sample_out,
   output logic                                  rsp_frame_last,
   output logic [agc_pkg::GAIN_INT_W-1:0]        rsp_gain_applied,
   input  wire logic                             csr_wr_en,
   input  wire logic [agc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [agc_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   agc_pkg::cfg_type     cfg_ff;
   agc_pkg::desc_type    push_desc;
   agc_pkg::desc_type    pop_desc;
   agc_pkg::release_type release_info;

   logic                        wr_en;
   logic [MAX_FRAME_ORDER:0]    wr_addr;
   logic [agc_pkg::SAMPLE_W-1:0] wr_data;
   logic                        push;
   logic                        pop;
   logic                        queue_full;
   logic                        queue_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_order     <= 3'd5;
         cfg_ff.power_threshold <= 31'd25000000;
         cfg_ff.gain_increment  <= 26'd11237;
         cfg_ff.gain_decrement  <= 26'd374582;
         cfg_ff.hold_frames     <= 16'd137;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            agc_pkg::REG_FRAME_ORDER:     cfg_ff.frame_order     <= csr_wr_data[2:0];
            agc_pkg::REG_POWER_THRESHOLD: cfg_ff.power_threshold <= csr_wr_data;
            agc_pkg::REG_GAIN_INCREMENT:  cfg_ff.gain_increment  <= csr_wr_data[25:0];
            agc_pkg::REG_GAIN_DECREMENT:  cfg_ff.gain_decrement  <= csr_wr_data[25:0];
            agc_pkg::REG_HOLD_FRAMES:     cfg_ff.hold_frames     <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   // intake, energy and gain update
   agc_front #(
      .MAX_FRAME_ORDER (MAX_FRAME_ORDER)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .push          (push),
      .push_desc     (push_desc),
      .queue_full    (queue_full),
      .release_info  (release_info)
   );

   // finished frame queue
   agc_desc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // frame buffer and output pipeline
   agc_back #(
      .MAX_FRAME_ORDER (MAX_FRAME_ORDER)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .queue_empty      (queue_empty),
      .queue_desc       (pop_desc),
      .pop              (pop),
      .release_info     (release_info),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_gain_applied (rsp_gain_applied)
   );

endmodule

`default_nettype wire

FILE: tb/audio_agc_soft_limiter_core_tb.sv
// ----------------------------------------------------------------------------
// audio_agc_soft_limiter_core_tb
// Self-checking bench for the frame-based gain control core. Samples go in
// as requests with random gaps and the responses meet random stalls. A
// predictor keeps its own frame buffer, energy sum, hold count and Q16.16
// gain. Each output sample is compared field by field with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module audio_agc_soft_limiter_core_tb;

   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     SETTLE_CYCLES = 16;
   localparam int     DRAIN_CYCLES  = 24;
   localparam int     FRAME_DEPTH   = 1 << agc_pkg::MAX_FRAME_ORDER;
   localparam longint CLIP_LEVEL    = 31744;
   localparam longint GAIN_CEIL     = longint'(1024) << 16;
   localparam longint GAIN_FLOOR    = longint'(256) << 16;
   localparam logic [25:0] STEP_MAX   = 26'h3ffffff;
   localparam logic [30:0] THRESH_MAX = 31'h7fffffff;

   typedef struct packed {
      logic [agc_pkg::SAMPLE_W-1:0]   sample_out;
      logic                           frame_last;
      logic [agc_pkg::GAIN_INT_W-1:0] gain_applied;
   } shaped_result_type;

   // dut signals
   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [agc_pkg::SAMPLE_W-1:0]     req_sample_in;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [agc_pkg::SAMPLE_W-1:0]     rsp_sample_out;
   logic                             rsp_frame_last;
   logic [agc_pkg::GAIN_INT_W-1:0]   rsp_gain_applied;
   logic                             csr_wr_en;
   logic [agc_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [agc_pkg::CSR_DATA_W-1:0]   csr_wr_data;

   // predictor state
   agc_pkg::cfg_type         agc_cfg;
   logic signed [15:0]       frame_buf [FRAME_DEPTH];
   int                       frame_fill;
   longint                   frame_energy;
   longint                   gain_q16;
   int                       hold_count;
   shaped_result_type        shaped_sample_q [$];

   // run control
   int   fail_count    = 0;
   int   cycle_count   = 0;
   logic req_calm      = 1'b0;
   logic rsp_calm      = 1'b0;
   int   hold_off_id   = 0;
   int   hold_off_len  = 0;
   int   hold_off_seen = 0;
   int   hold_off_left = 0;
   int   stall_run     = 0;

   audio_agc_soft_limiter_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_gain_applied (rsp_gain_applied),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // soft-clip slope drops by 12 per step
   function automatic longint clip_slope(input int k);
      return longint'(244 - 12 * k);
   endfunction

   // knee grows by 3, 6, 9, ... per step
   function automatic longint clip_knee(input int k);
      return longint'(31744 + (3 * k * (k + 1)) / 2);
   endfunction

   // gain multiply with floor shift, soft knee above the barrier, saturate
   function automatic logic [15:0] limit_sample(input logic signed [15:0] s,
                                                 input longint gain_int);
      longint v;
      longint over;
      longint mag;
      int     k;
      v   = (longint'(s) * gain_int) >>> 8;
      mag = (v < 0) ? -v : v;
      if (mag > CLIP_LEVEL) begin
         over = (v > 0) ? v - CLIP_LEVEL : v + CLIP_LEVEL;
         mag  = (over < 0) ? -over : over;
         k    = int'((mag >> 6) & 15);
         over = (over * clip_slope(k)) >>> 8;
         v    = (v > 0) ? clip_knee(k) + over : over - clip_knee(k);
      end
      if (v > 32767)
         v = 32767;
      else if (v < -32768)
         v = -32768;
      return v[15:0];
   endfunction

   // buffer one sample; on a full frame update gain and queue the frame
   function automatic void agc_take_sample(input logic signed [15:0] s);
      int                order;
      longint            mean;
      longint            gain_int;
      shaped_result_type r;
      order = int'(agc_cfg.frame_order);
      if (order > agc_pkg::MAX_FRAME_ORDER)
         order = agc_pkg::MAX_FRAME_ORDER;
      if (order < agc_pkg::MIN_FRAME_ORDER)
         order = agc_pkg::MIN_FRAME_ORDER;
      frame_buf[frame_fill] = s;
      frame_energy += longint'(s) * longint'(s);
      frame_fill++;
      if (frame_fill < (1 << order))
         return;
      // attack on loud frames, hold then release on quiet ones
      mean = frame_energy >> order;
      if (mean < longint'(agc_cfg.power_threshold)) begin
         if (hold_count > 0)
            hold_count--;
         else
            gain_q16 += longint'(agc_cfg.gain_increment);
      end else begin
         gain_q16  -= longint'(agc_cfg.gain_decrement);
         hold_count = int'(agc_cfg.hold_frames);
      end
      if (gain_q16 > GAIN_CEIL)
         gain_q16 = GAIN_CEIL;
      else if (gain_q16 < GAIN_FLOOR)
         gain_q16 = GAIN_FLOOR;
      gain_int = gain_q16 >>> 16;
      for (int i = 0; i < frame_fill; i++) begin
         r.sample_out   = limit_sample(frame_buf[i], gain_int);
         r.frame_last   = (i == frame_fill - 1);
         r.gain_applied = gain_int[agc_pkg::GAIN_INT_W-1:0];
         shaped_sample_q.push_back(r);
      end
      frame_fill   = 0;
      frame_energy = 0;
   endfunction

   // idle length: mostly minimal, some short, a few long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 1;
      if (r < 92)
         return $urandom_range(2, 4);
      return $urandom_range(12, 40);
   endfunction

   // random sample within +-amp, full 16-bit range for amp 32768
   function automatic logic signed [15:0] rand_sample(input int amp);
      logic [31:0] raw;
      int          v;
      raw = $urandom();
      if (amp >= 32768)
         return raw[15:0];
      v = int'($urandom_range(0, 2 * amp)) - amp;
      return v[15:0];
   endfunction

   // register write, predictor copy follows
   task automatic write_reg(input logic [agc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [agc_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         agc_pkg::REG_FRAME_ORDER:     agc_cfg.frame_order     = data[2:0];
         agc_pkg::REG_POWER_THRESHOLD: agc_cfg.power_threshold = data[30:0];
         agc_pkg::REG_GAIN_INCREMENT:  agc_cfg.gain_increment  = data[25:0];
         agc_pkg::REG_GAIN_DECREMENT:  agc_cfg.gain_decrement  = data[25:0];
         agc_pkg::REG_HOLD_FRAMES:     agc_cfg.hold_frames     = data[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one request, held until accepted
   task automatic send_sample(input logic signed [15:0] s);
      int gap;
      gap = (req_calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      agc_take_sample(s);
   endtask

   // stop sending, wait for every predicted result, let intake settle
   task automatic quiesce_requests();
      req_valid <= 1'b0;
      while (shaped_sample_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one frame at the power-up register values
   task automatic test_reset_defaults();
      rsp_calm = 1'b1;
      for (int i = 0; i < 32; i++)
         send_sample(rand_sample(($urandom_range(0, 1) == 1) ? 32768 : 2000));
      quiesce_requests();
      rsp_calm = 1'b0;
   endtask

   // sample extremes, barrier edges, clip index wrap, both gain clamps
   task automatic test_directed_extremes();
      req_calm = 1'b1;
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 3);
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 0);
      write_reg(agc_pkg::REG_HOLD_FRAMES, 0);
      write_reg(agc_pkg::REG_GAIN_INCREMENT, 31'(STEP_MAX));
      write_reg(agc_pkg::REG_GAIN_DECREMENT, 0);
      // zero threshold: always loud, gain stays at 1.0
      send_sample(32767);  send_sample(-32768); send_sample(0);      send_sample(1);
      send_sample(-1);     send_sample(31744);  send_sample(31745);  send_sample(-31745);
      quiesce_requests();
      // max threshold: quiet, full release clamps gain at 4.0
      write_reg(agc_pkg::REG_POWER_THRESHOLD, THRESH_MAX);
      send_sample(32767);  send_sample(-32768); send_sample(8000);   send_sample(-7937);
      send_sample(7936);   send_sample(9000);   send_sample(-16384); send_sample(-1);
      quiesce_requests();
      // full attack clamps gain back at 1.0
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 1);
      write_reg(agc_pkg::REG_GAIN_DECREMENT, 31'(STEP_MAX));
      send_sample(32767);  send_sample(-32768); send_sample(32000);  send_sample(-32000);
      send_sample(31745);  send_sample(-31744); send_sample(2);      send_sample(-2);
      quiesce_requests();
      req_calm = 1'b0;
   endtask

   // frame order values below, inside and above the supported range
   task automatic test_order_range();
      int len;
      for (int o = 0; o < 8; o++) begin
         if (o != 3 && o != 5) begin
            quiesce_requests();
            write_reg(agc_pkg::REG_FRAME_ORDER, 31'(o));
            write_reg(agc_pkg::REG_POWER_THRESHOLD,
                      (o % 2 == 0) ? THRESH_MAX : 31'($urandom_range(1, 1 << 30)));
            write_reg(agc_pkg::REG_GAIN_INCREMENT, 31'($urandom_range(0, 1 << 23)));
            len = (o < 3) ? 8 : (o > 5) ? 32 : (1 << o);
            for (int i = 0; i < len; i++)
               send_sample(rand_sample(($urandom_range(0, 3) == 0) ? 32768 : 3000));
         end
      end
      quiesce_requests();
   endtask

   // frame length shrunk while part of a frame is buffered, then grown
   task automatic test_order_change_mid_frame();
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 5);
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 10000000);
      for (int i = 0; i < 20; i++)
         send_sample(rand_sample(32768));
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 4);
      send_sample(rand_sample(32768));
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 3);
      for (int i = 0; i < 5; i++)
         send_sample(rand_sample(1000));
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 5);
      for (int i = 0; i < 27; i++)
         send_sample(rand_sample(1000));
      quiesce_requests();
   endtask

   // mean exactly at the threshold attacks, one below releases
   task automatic test_threshold_boundary();
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 3);
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 1000000);
      write_reg(agc_pkg::REG_HOLD_FRAMES, 0);
      write_reg(agc_pkg::REG_GAIN_INCREMENT, 31'($urandom_range(1 << 16, 1 << 22)));
      write_reg(agc_pkg::REG_GAIN_DECREMENT, 31'($urandom_range(1 << 16, 1 << 22)));
      for (int i = 0; i < 8; i++)
         send_sample((i % 2 == 0) ? 1000 : -1000);
      quiesce_requests();
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 1000001);
      for (int i = 0; i < 8; i++)
         send_sample((i % 2 == 0) ? 1000 : -1000);
      quiesce_requests();
   endtask

   // attack, hold and release over runs of loud, mid and quiet frames
   task automatic test_gain_trajectory();
      logic [25:0] inc;
      logic [25:0] dec;
      logic [15:0] hold;
      logic [30:0] thr;
      int          amp;
      for (int p = 0; p < 4; p++) begin
         quiesce_requests();
         case (p)
            0: begin inc = 0; dec = 0; hold = 16'hffff; end
            1: begin
               inc  = 26'($urandom_range(1 << 12, 1 << 22));
               dec  = 26'($urandom_range(1 << 12, 1 << 22));
               hold = 0;
            end
            2: begin inc = STEP_MAX; dec = 26'($urandom_range(0, 1 << 20)); hold = 1; end
            default: begin
               inc  = 26'($urandom_range(0, 1 << 24));
               dec  = STEP_MAX;
               hold = 16'($urandom_range(0, 2));
            end
         endcase
         case ($urandom_range(0, 2))
            0:       thr = 2000000;
            1:       thr = 50000000;
            default: thr = 31'($urandom_range(1, 1 << 30));
         endcase
         write_reg(agc_pkg::REG_FRAME_ORDER, 3);
         write_reg(agc_pkg::REG_POWER_THRESHOLD, thr);
         write_reg(agc_pkg::REG_GAIN_INCREMENT, 31'(inc));
         write_reg(agc_pkg::REG_GAIN_DECREMENT, 31'(dec));
         write_reg(agc_pkg::REG_HOLD_FRAMES, 31'(hold));
         for (int f = 0; f < 3; f++) begin
            case ($urandom_range(0, 2))
               0:       amp = 32768;
               1:       amp = 4000;
               default: amp = 300;
            endcase
            for (int i = 0; i < 8; i++)
               send_sample(rand_sample(amp));
         end
      end
      quiesce_requests();
   endtask

   // receiver holds off long enough for both banks to fill and stall intake
   task automatic test_output_backpressure();
      quiesce_requests();
      write_reg(agc_pkg::REG_FRAME_ORDER, 3);
      write_reg(agc_pkg::REG_POWER_THRESHOLD, 31'($urandom_range(1, 1 << 30)));
      req_calm     = 1'b1;
      rsp_calm     = 1'b1;
      hold_off_len = 200;
      hold_off_id++;
      for (int i = 0; i < 48; i++)
         send_sample(rand_sample(32768));
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      quiesce_requests();
   endtask

   // response stall: random gaps, plus long hold-offs on request
   always @(posedge clock) begin : drive_rsp_stall
      logic stall_next;
      if (hold_off_seen != hold_off_id) begin
         hold_off_seen = hold_off_id;
         hold_off_left = hold_off_len;
      end
      if (hold_off_left > 0) begin
         stall_next = 1'b1;
         hold_off_left--;
      end else if (stall_run > 0) begin
         stall_next = 1'b1;
         stall_run--;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
         stall_next = 1'b1;
         stall_run  = idle_span() - 1;
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      shaped_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (shaped_sample_q.size() == 0) begin
            $error("unexpected result: sample_out %0d", $signed(rsp_sample_out));
            fail_count++;
         end else begin
            want = shaped_sample_q.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d",
                      $signed(want.sample_out), $signed(rsp_sample_out));
               fail_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0d, got %0d", want.frame_last, rsp_frame_last);
               fail_count++;
            end
            if (rsp_gain_applied !== want.gain_applied) begin
               $error("gain_applied: expected %0d, got %0d",
                      want.gain_applied, rsp_gain_applied);
               fail_count++;
            end
         end
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("audio_agc_soft_limiter_core_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= '0;
      csr_wr_data   <= '0;
      // predictor at power-up values
      agc_cfg.frame_order     = 3'd5;
      agc_cfg.power_threshold = 31'd25000000;
      agc_cfg.gain_increment  = 26'd11237;
      agc_cfg.gain_decrement  = 26'd374582;
      agc_cfg.hold_frames     = 16'd137;
      frame_fill   = 0;
      frame_energy = 0;
      gain_q16     = GAIN_FLOOR;
      hold_count   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_extremes();
      test_order_range();
      test_order_change_mid_frame();
      test_threshold_boundary();
      test_gain_trajectory();
      test_output_backpressure();
      quiesce_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("audio_agc_soft_limiter_core_tb: PASS");
      else
         $display("audio_agc_soft_limiter_core_tb: FAIL");
      $finish;
   end

endmodule
